[rtl/core/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define OFV_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// default form on clk_i and rst_ni
`define OFV_ASSERT(lbl, prop, msg) \
  `OFV_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/ofv_pkg.sv]
package ofv_pkg;

  localparam int unsigned MAX_SLOTS       = 1048576;
  localparam int unsigned MIN_TABLE_BYTES = 8;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BASE_W   = 48;
  localparam int unsigned OFFS_W   = BASE_W + 1;
  localparam int unsigned SLOT_W   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned INDEX_W  = 20;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned VERD_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = BASE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SPAN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 1'd1;

  // verdict codes
  localparam logic [VERD_W-1:0] VERD_VALID        = 3'd0;
  localparam logic [VERD_W-1:0] VERD_BAD_LENGTH   = 3'd1;
  localparam logic [VERD_W-1:0] VERD_DECREASING   = 3'd2;
  localparam logic [VERD_W-1:0] VERD_BEYOND_SPAN  = 3'd3;
  localparam logic [VERD_W-1:0] VERD_UNTERMINATED = 3'd4;
  localparam logic [VERD_W-1:0] VERD_NONZERO_PAD  = 3'd5;
  localparam logic [VERD_W-1:0] VERD_NO_MEMBERS   = 3'd6;

  // record kinds
  localparam logic KIND_MEMBER  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                record_kind;
    logic [COUNT_W-1:0]  member_number;
    logic [OFFS_W-1:0]   member_offset;
    logic [WORD_W-1:0]   member_size;
    logic [INDEX_W-1:0]  entry_index;
    logic [VERD_W-1:0]   verdict;
    logic [COUNT_W-1:0]  member_total;
    logic                last_result;
  } result_t;

  // up to two records written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    result_t    rec0;
    result_t    rec1;
  } push_t;

endpackage

[rtl/core/offset_table_validator.sv]
// Offset table validator. Feed the table one 32-bit word per transaction, with
// first_word_i set on the length word that opens a table. Each word is checked
// in the cycle it is accepted, against state kept from the previous word, so a
// new word can be taken on every clock with in_ready_o high: one word per cycle.
// A word makes zero, one or two output transactions (a member record, then a
// verdict when the table ends on that word); these go into a four-entry result
// queue, and the first of them shows on the output once older records drain.
// Output drains one record per cycle while out_ready_i is high; in_ready_o
// drops only while the queue has fewer than two free entries, i.e. on a stall.
// Once a verdict is out, words are ignored until the next first word; a first
// word in the middle of a table drops the old table without a verdict.
// If the verdict is not valid, the consumer discards members already seen.
// file_span and base_offset are to be written through the cfg port only when
// the block is idle; the block itself does not enforce this.
module offset_table_validator
  import ofv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // table words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [WORD_W-1:0]     table_word_i,
  input  logic                  first_word_i,
  // member and verdict records
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  record_kind_o,
  output logic [COUNT_W-1:0]    member_number_o,
  output logic [OFFS_W-1:0]     member_offset_o,
  output logic [WORD_W-1:0]     member_size_o,
  output logic [INDEX_W-1:0]    entry_index_o,
  output logic [VERD_W-1:0]     verdict_o,
  output logic [COUNT_W-1:0]    member_total_o,
  output logic                  last_result_o
);

  // walk phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WALK = 2'd1;
  localparam logic [1:0] PH_PAD  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // configuration registers
  logic [WORD_W-1:0]  file_span_q;
  logic [BASE_W-1:0]  base_offset_q;

  // walk state
  logic [1:0]         phase_q, phase_d;
  logic [WORD_W-1:0]  prev_q, prev_d;
  logic [SLOT_W-1:0]  slot_total_q, slot_total_d;
  logic [SLOT_W-1:0]  slot_index_q, slot_index_d;
  logic [COUNT_W-1:0] counter_q, counter_d;

  logic               in_fire;
  logic               last_slot;
  logic               bad_length;
  logic [SLOT_W-1:0]  slot_prev;
  push_t              push;
  result_t            head;
  logic               room_two;

  assign in_ready_o = room_two;
  assign in_fire    = in_valid_i && in_ready_o;

  // next slot index reaching the table length means this is the last slot
  assign last_slot = ({1'b0, slot_index_q} + (SLOT_W + 1)'(1)) >= {1'b0, slot_total_q};
  assign slot_prev = slot_index_q - SLOT_W'(1);

  // length word checks: minimum size, word aligned, inside the file, slot limit
  assign bad_length = (table_word_i < WORD_W'(MIN_TABLE_BYTES)) ||
                      (table_word_i[1:0] != 2'b00) ||
                      (table_word_i > file_span_q) ||
                      (table_word_i[WORD_W-1:2] > (WORD_W - 2)'(MAX_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_span_q   <= '0;
      base_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FILE_SPAN:   file_span_q   <= cfg_data_i[WORD_W-1:0];
        CFG_BASE_OFFSET: base_offset_q <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic        mem_push;
    logic        ver_push;
    logic [VERD_W-1:0] ver_code;
    result_t     mem_rec;
    result_t     ver_rec;

    phase_d      = phase_q;
    prev_d       = prev_q;
    slot_total_d = slot_total_q;
    slot_index_d = slot_index_q;
    counter_d    = counter_q;
    mem_push     = 1'b0;
    ver_push     = 1'b0;
    ver_code     = VERD_VALID;

    if (in_fire) begin
      if (first_word_i) begin
        counter_d = '0;
        if (bad_length) begin
          prev_d       = '0;
          slot_total_d = '0;
          slot_index_d = '0;
          ver_push     = 1'b1;
          ver_code     = VERD_BAD_LENGTH;
        end else begin
          prev_d       = table_word_i;
          slot_total_d = SLOT_W'(table_word_i >> 2);
          slot_index_d = SLOT_W'(1);
          phase_d      = PH_WALK;
        end
      end else begin
        case (phase_q)
          PH_WALK: begin
            slot_index_d = slot_index_q + SLOT_W'(1);
            if ((prev_q == file_span_q) && (table_word_i == '0)) begin
              // terminator reached, zero word: done or padding follows
              if (last_slot) begin
                ver_push = 1'b1;
              end else begin
                phase_d = PH_PAD;
              end
            end else if (table_word_i < prev_q) begin
              ver_push = 1'b1;
              ver_code = VERD_DECREASING;
            end else if (table_word_i > file_span_q) begin
              ver_push = 1'b1;
              ver_code = VERD_BEYOND_SPAN;
            end else begin
              if (table_word_i != prev_q) begin
                mem_push  = 1'b1;
                counter_d = counter_q + COUNT_W'(1);
              end
              prev_d = table_word_i;
              if (last_slot) begin
                ver_push = 1'b1;
                if (table_word_i != file_span_q) begin
                  ver_code = VERD_UNTERMINATED;
                end
              end
            end
          end
          PH_PAD: begin
            slot_index_d = slot_index_q + SLOT_W'(1);
            if (table_word_i != '0) begin
              ver_push = 1'b1;
              ver_code = VERD_NONZERO_PAD;
            end else if (last_slot) begin
              ver_push = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    // a clean end with no members is its own verdict
    if ((ver_code == VERD_VALID) && (counter_d == '0)) begin
      ver_code = VERD_NO_MEMBERS;
    end
    if (ver_push) begin
      phase_d = PH_DONE;
    end

    mem_rec               = '0;
    mem_rec.record_kind   = KIND_MEMBER;
    mem_rec.member_number = counter_d;
    mem_rec.member_offset = {1'b0, base_offset_q} + OFFS_W'(prev_q);
    mem_rec.member_size   = table_word_i - prev_q;
    mem_rec.entry_index   = slot_prev[INDEX_W-1:0];
    mem_rec.last_result   = !ver_push;

    ver_rec              = '0;
    ver_rec.record_kind  = KIND_VERDICT;
    ver_rec.verdict      = ver_code;
    ver_rec.member_total = counter_d;
    ver_rec.last_result  = 1'b1;

    push.count = 2'(mem_push) + 2'(ver_push);
    push.rec0  = mem_push ? mem_rec : ver_rec;
    push.rec1  = ver_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      prev_q       <= '0;
      slot_total_q <= '0;
      slot_index_q <= '0;
      counter_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      prev_q       <= prev_d;
      slot_total_q <= slot_total_d;
      slot_index_q <= slot_index_d;
      counter_q    <= counter_d;
    end
  end

  // result queue between the checks and the consumer
  ofv_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_two_o (room_two),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .head_o     (head)
  );

  assign record_kind_o   = head.record_kind;
  assign member_number_o = head.member_number;
  assign member_offset_o = head.member_offset;
  assign member_size_o   = head.member_size;
  assign entry_index_o   = head.entry_index;
  assign verdict_o       = head.verdict;
  assign member_total_o  = head.member_total;
  assign last_result_o   = head.last_result;

endmodule

[rtl/core/ofv_result_fifo.sv]
module ofv_result_fifo
  import ofv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_two_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t head_o
);

  result_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]  count_q, count_d;
  logic [FIFO_PTR_W-1:0]  wr_ptr_nxt;
  logic                   pop;

  assign valid_o    = (count_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign pop        = valid_o && ready_i;
  assign room_two_o = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_nxt = wr_ptr_q + FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + FIFO_CNT_W'(push_i.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.rec1;
    end
  end

endmodule

[rtl/core/ofv_checker.sv]
`include "assert_macros.svh"

module ofv_checker
  import ofv_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               record_kind_o,
  input logic [COUNT_W-1:0] member_number_o,
  input logic [WORD_W-1:0]  member_size_o,
  input logic [VERD_W-1:0]  verdict_o,
  input logic               last_result_o
);

  // a pending record is not withdrawn
  `OFV_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output valid dropped")

  // a verdict always closes the word's records
  `OFV_ASSERT(a_verdict_last, out_valid_o && record_kind_o == KIND_VERDICT |-> last_result_o, "verdict without last flag")

  // member records carry a real gap, a counted number and a valid verdict field
  `OFV_ASSERT(a_member_fields, out_valid_o && record_kind_o == KIND_MEMBER |-> member_size_o != '0 && member_number_o != '0 && verdict_o == VERD_VALID, "bad member record")

  // verdict codes stay within the defined set
  `OFV_ASSERT(a_verdict_code, out_valid_o && record_kind_o == KIND_VERDICT |-> verdict_o <= VERD_NO_MEMBERS, "undefined verdict code")

endmodule

bind offset_table_validator ofv_checker u_ofv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .record_kind_o   (record_kind_o),
  .member_number_o (member_number_o),
  .member_size_o   (member_size_o),
  .verdict_o       (verdict_o),
  .last_result_o   (last_result_o)
);

[tb/sv/testbench.sv]
module testbench;
  import ofv_pkg::*;

  localparam int unsigned IDLE_PCT      = 14;    // idle cycles per hundred on each side
  localparam int unsigned LONG_STALL    = 300;   // consumer hold-off, in cycles
  localparam int unsigned SETTLE_CYCLES = 8;     // pipeline drain after the last record
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no transaction before giving up

  // one table word as the producer offers it
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              first;
  } table_item_t;

  // predicted walk position inside the current table
  typedef enum logic [1:0] {WALK_IDLE, WALK_ENTRIES, WALK_PAD, WALK_DONE} walk_e;

  // ways a generated table gets broken on purpose
  typedef enum int unsigned {
    DEF_NONE, DEF_RANDOM, DEF_DECREASE, DEF_BEYOND, DEF_PAD, DEF_OPEN, DEF_CUT
  } defect_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_FILE_SPAN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [WORD_W-1:0]     table_word_i = '0;
  logic                  first_word_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  record_kind_o;
  logic [COUNT_W-1:0]    member_number_o;
  logic [OFFS_W-1:0]     member_offset_o;
  logic [WORD_W-1:0]     member_size_o;
  logic [INDEX_W-1:0]    entry_index_o;
  logic [VERD_W-1:0]     verdict_o;
  logic [COUNT_W-1:0]    member_total_o;
  logic                  last_result_o;

  offset_table_validator DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // words waiting to be offered, and records the block still owes us
  table_item_t pending_words[$];
  result_t     records_due[$];

  // shadow copy of the configuration registers
  logic [WORD_W-1:0] span_reg = '0;
  logic [BASE_W-1:0] base_reg = '0;

  // shadow copy of the walk state
  walk_e              walk_phase = WALK_IDLE;
  logic [WORD_W-1:0]  prior_entry = '0;
  logic [COUNT_W-1:0] slots_in_table = '0;
  logic [COUNT_W-1:0] slot_at = '0;
  logic [COUNT_W-1:0] members_seen = '0;

  // traffic shaping knobs, changed by the stimulus process at falling edges
  bit          steady = 1'b0;       // no random idling on either side
  bit          sender_hold = 1'b0;  // producer stops offering new words
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned stall_left = 0;

  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  bit          offering;
  table_item_t next_item;
  result_t     want;

  // --------------------------------------------------------------------------
  // table walk prediction
  // --------------------------------------------------------------------------

  function automatic logic [VERD_W-1:0] closing_code();
    return (members_seen != '0) ? VERD_VALID : VERD_NO_MEMBERS;
  endfunction

  // verdict record; the table is finished once one is out
  function automatic result_t verdict_record(input logic [VERD_W-1:0] code);
    result_t rec;
    rec = '0;
    rec.record_kind  = KIND_VERDICT;
    rec.verdict      = code;
    rec.member_total = members_seen;
    walk_phase = WALK_DONE;
    return rec;
  endfunction

  // advance the walk by one accepted word and queue the records it yields
  function automatic void walk_table_word(input logic [WORD_W-1:0] w, input logic first);
    result_t recs[$];
    result_t rec;
    logic    at_end;
    at_end = (32'(slot_at) + 32'd1) >= 32'(slots_in_table);
    if (first) begin
      // a length word restarts everything, even in the middle of a table
      prior_entry    = '0;
      slots_in_table = '0;
      slot_at        = '0;
      members_seen   = '0;
      if (w < MIN_TABLE_BYTES || w[1:0] != 2'b00 || w > span_reg || (w >> 2) > MAX_SLOTS) begin
        recs.push_back(verdict_record(VERD_BAD_LENGTH));
      end else begin
        prior_entry    = w;
        slots_in_table = w[COUNT_W+1:2];
        slot_at        = 1;
        walk_phase     = WALK_ENTRIES;
      end
    end else if (walk_phase == WALK_ENTRIES) begin
      if (prior_entry == span_reg && w == '0) begin
        // terminator reached, the rest must be zero padding
        if (at_end) recs.push_back(verdict_record(closing_code()));
        else walk_phase = WALK_PAD;
      end else if (w < prior_entry) begin
        recs.push_back(verdict_record(VERD_DECREASING));
      end else if (w > span_reg) begin
        recs.push_back(verdict_record(VERD_BEYOND_SPAN));
      end else begin
        // zero gaps give no member
        if (w != prior_entry) begin
          members_seen = members_seen + 1'b1;
          rec = '0;
          rec.record_kind   = KIND_MEMBER;
          rec.member_number = members_seen;
          rec.member_offset = OFFS_W'(base_reg) + OFFS_W'(prior_entry);
          rec.member_size   = w - prior_entry;
          rec.entry_index   = INDEX_W'(slot_at - 1'b1);
          recs.push_back(rec);
        end
        prior_entry = w;
        if (at_end)
          recs.push_back(verdict_record(w == span_reg ? closing_code() : VERD_UNTERMINATED));
      end
      slot_at = slot_at + 1'b1;
    end else if (walk_phase == WALK_PAD) begin
      if (w != '0) recs.push_back(verdict_record(VERD_NONZERO_PAD));
      else if (at_end) recs.push_back(verdict_record(closing_code()));
      slot_at = slot_at + 1'b1;
    end
    // idle and done phases swallow the word silently
    if (recs.size() != 0) recs[recs.size()-1].last_result = 1'b1;
    foreach (recs[i]) records_due.push_back(recs[i]);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // producer: offers queued words, predicts on every input transaction
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        walk_table_word(table_word_i, first_word_i);
        words_taken++;
        offering = 1'b0;
      end
      // a word already on the bus stays put until taken
      if (!offering && pending_words.size() != 0 && !sender_hold &&
          (steady || $urandom_range(99) >= IDLE_PCT)) begin
        next_item = pending_words.pop_front();
        table_word_i <= next_item.word;
        first_word_i <= next_item.first;
        offering = 1'b1;
      end
      in_valid_i <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // consumer: checks every output transaction against the oldest prediction
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (records_due.size() == 0) begin
          $error("record with nothing expected: kind %0d verdict %0d", record_kind_o,
                 verdict_o);
          mismatches++;
        end else begin
          want = records_due.pop_front();
          check_field("record_kind", want.record_kind, record_kind_o);
          check_field("member_number", want.member_number, member_number_o);
          check_field("member_offset", want.member_offset, member_offset_o);
          check_field("member_size", want.member_size, member_size_o);
          check_field("entry_index", want.entry_index, entry_index_o);
          check_field("verdict", want.verdict, verdict_o);
          check_field("member_total", want.member_total, member_total_o);
          check_field("last_result", want.last_result, last_result_o);
        end
      end
      // long hold-off so the result queue fills and backpressure reaches the input
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = LONG_STALL;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  function automatic void queue_word(input logic [WORD_W-1:0] word, input logic first);
    table_item_t item;
    item.word  = word;
    item.first = first;
    pending_words.push_back(item);
  endfunction

  // one table for the current span: mostly well formed, some broken on purpose
  function automatic void queue_table();
    logic [WORD_W-1:0] ent[$];
    int unsigned       slot_cap, slots, term, keep, c, i;
    defect_e           defect;
    if (span_reg < MIN_TABLE_BYTES || $urandom_range(19) == 0) begin
      // lone length word, almost always rejected
      queue_word((span_reg < MIN_TABLE_BYTES) ? 32'($urandom_range(12)) : $urandom(), 1'b1);
      return;
    end
    slot_cap = (span_reg / 4 > 64) ? 64 : span_reg / 4;
    slots = ($urandom_range(7) == 0) ? $urandom_range(slot_cap, 2)
                                     : $urandom_range((slot_cap > 10) ? 10 : slot_cap, 2);
    term = $urandom_range(slots - 1, 1);  // slot holding the span terminator
    ent.push_back(slots * 4);
    for (i = 1; i < term; i++) ent.push_back($urandom_range(span_reg, slots * 4));
    ent.sort();
    // repeated entries make zero gaps, which give no member
    for (i = 1; i < term; i++) if ($urandom_range(4) == 0) ent[i] = ent[i-1];
    ent.push_back(span_reg);
    while (ent.size() < slots) ent.push_back('0);

    defect = ($urandom_range(9) < 3) ? defect_e'($urandom_range(DEF_CUT, DEF_RANDOM))
                                     : DEF_NONE;
    case (defect)
      DEF_RANDOM: begin
        ent[$urandom_range(slots - 1, 1)] = $urandom();
      end
      DEF_DECREASE: begin
        c = $urandom_range(term, 1);
        ent[c] = $urandom_range(ent[c-1] - 1, 0);
      end
      DEF_BEYOND: begin
        if (span_reg != '1) ent[$urandom_range(term, 1)] = $urandom_range('1, span_reg + 1);
      end
      DEF_PAD: begin
        if (term < slots - 1) ent[$urandom_range(slots - 1, term + 1)] = $urandom_range('1, 1);
      end
      DEF_OPEN: begin
        // never reach the span, so the table runs out unterminated
        if (ent[term-1] < span_reg)
          for (i = term; i < slots; i++) ent[i] = $urandom_range(span_reg - 1, ent[i-1]);
      end
      DEF_CUT: begin
        // next length word lands in the middle of this table
        keep = $urandom_range(slots - 1, 1);
        while (ent.size() > keep) void'(ent.pop_back());
      end
      default: ;
    endcase
    foreach (ent[k]) queue_word(ent[k], k == 0);
    // stray word, usually after the verdict
    if ($urandom_range(7) == 0) queue_word($urandom(), 1'b0);
  endfunction

  task automatic set_register(input logic [CFG_IDX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    if (index == CFG_FILE_SPAN) span_reg = value[WORD_W-1:0];
    else base_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for all words taken and all records seen, then let the pipeline drain
  task automatic settle();
    while (pending_words.size() != 0 || in_valid_i || records_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned count, input bit long_stall, input bit pause);
    int unsigned mark;
    @(negedge clk_i);
    while (pending_words.size() < count) queue_table();
    if (long_stall) hold_requests++;
    if (pause) begin
      // halfway through, stop offering until the block has emptied out
      mark = words_taken + count / 2;
      while (words_taken < mark) @(negedge clk_i);
      sender_hold = 1'b1;
      while (in_valid_i || records_due.size() != 0) @(negedge clk_i);
      sender_hold = 1'b0;
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed cases on a 64-byte span with the base at its top
    set_register(CFG_FILE_SPAN, 48'd64);
    set_register(CFG_BASE_OFFSET, '1);
    @(negedge clk_i);
    queue_word(32'h5, 1'b0);                       // before any table, ignored
    queue_word(32'd4, 1'b1);                       // length too small
    queue_word(32'd10, 1'b1);                      // length not word aligned
    queue_word(32'd68, 1'b1);                      // length past the span
    queue_word(32'd16, 1'b1); queue_word(32'd16, 1'b0);  // empty gap skipped,
    queue_word(32'd40, 1'b0); queue_word(32'd64, 1'b0);  // member then verdict on last word
    queue_word(32'd12, 1'b1); queue_word(32'd64, 1'b0);  // zero right after the terminator
    queue_word(32'd0, 1'b0);
    queue_word(32'd16, 1'b1); queue_word(32'd32, 1'b0);  // decreasing entry,
    queue_word(32'd20, 1'b0); queue_word(32'd77, 1'b0);  // then a word after the verdict
    queue_word(32'd8, 1'b1); queue_word(32'd65, 1'b0);   // entry beyond the span
    queue_word(32'd16, 1'b1); queue_word(32'd64, 1'b0);  // nonzero word in the padding
    queue_word(32'd0, 1'b0); queue_word(32'd5, 1'b0);
    queue_word(32'd16, 1'b1); queue_word(32'd20, 1'b0);  // table cut short by
    queue_word(32'd8, 1'b1); queue_word(32'd8, 1'b0);    // an unterminated one
    settle();

    // length equal to the span: tables with no members
    set_register(CFG_FILE_SPAN, 48'd8);
    set_register(CFG_BASE_OFFSET, '0);
    @(negedge clk_i);
    queue_word(32'd8, 1'b1); queue_word(32'd8, 1'b0);
    queue_word(32'd8, 1'b1); queue_word(32'd0, 1'b0);
    settle();

    // full span, slot limit edges, then random tables without any idling
    set_register(CFG_FILE_SPAN, 48'hFFFF_FFFF);
    set_register(CFG_BASE_OFFSET, '0);
    @(negedge clk_i);
    queue_word(32'(4 * MAX_SLOTS + 4), 1'b1);      // one slot too many
    queue_word(32'(4 * MAX_SLOTS), 1'b1);          // largest legal table, dropped early
    queue_word(32'hFFFF_FFFF, 1'b0);
    steady = 1'b1;
    random_phase(150, 1'b0, 1'b0);
    steady = 1'b0;

    // mid-size span, consumer holds off long enough to stall the input
    set_register(CFG_FILE_SPAN, 48'($urandom_range(4096, 8)));
    set_register(CFG_BASE_OFFSET, 48'({$urandom(), $urandom()}));
    random_phase(150, 1'b1, 1'b0);

    // any span, base at its top, producer pauses until drained
    set_register(CFG_FILE_SPAN, 48'($urandom_range(32'hFFFF_FFFF, 8)));
    set_register(CFG_BASE_OFFSET, '1);
    random_phase(150, 1'b0, 1'b1);

    // zero span: every length word is rejected
    set_register(CFG_FILE_SPAN, '0);
    set_register(CFG_BASE_OFFSET, '0);
    random_phase(20, 1'b0, 1'b0);

    // tiny spans, many short tables
    set_register(CFG_FILE_SPAN, 48'($urandom_range(64, 8)));
    set_register(CFG_BASE_OFFSET, 48'({$urandom(), $urandom()}));
    random_phase(170, 1'b0, 1'b0);

    // wider spans with both stall and pause
    set_register(CFG_FILE_SPAN, 48'($urandom_range(32'h0010_0000, 64)));
    set_register(CFG_BASE_OFFSET, 48'({$urandom(), $urandom()}));
    random_phase(160, 1'b1, 1'b1);

    if (mismatches == 0 && records_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (records_due.size() != 0) $error("%0d records never arrived", records_due.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[offset_table_validator.f]
+incdir+rtl/core
rtl/core/ofv_pkg.sv
rtl/core/ofv_result_fifo.sv
rtl/core/offset_table_validator.sv
rtl/core/ofv_checker.sv
tb/sv/testbench.sv
